// ===== src/apu_frame_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// apu frame sequencer assertion macros
// shared property shorthands for the port checker
// ----------------------------------------------------------------------------
`ifndef APU_FRAME_SEQUENCER_DEFINES_SVH
`define APU_FRAME_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define FSQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame sequencer check failed");

// next-cycle implication, disabled while in reset
`define FSQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame sequencer check failed");

`endif

// ===== src/fsq_pkg.sv =====
// ----------------------------------------------------------------------------
// fsq_pkg
// types and constants of the frame sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package fsq_pkg;

  localparam int unsigned PeriodW  = 14;
  localparam int unsigned CountW   = 16;
  localparam int unsigned OffsetW  = 5;
  localparam int unsigned DataW    = 8;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IRQ_PERIOD    = 2'd0,
    CFG_ENV_PERIOD    = 2'd1,
    CFG_LENGTH_PERIOD = 2'd2
  } cfg_idx_e;

  localparam logic [OffsetW-1:0] OFFS_STATUS = 5'h15;
  localparam logic [OffsetW-1:0] OFFS_FRAME  = 5'h17;

  localparam int unsigned MODE_BIT    = 7;
  localparam int unsigned INHIBIT_BIT = 6;

  localparam logic signed [CountW-1:0] CNT_RESET        = 16'sd4;
  localparam logic signed [CountW-1:0] CNT_RELOAD       = -16'sd1;
  localparam logic signed [CountW-1:0] CNT_RELOAD_LONG  = -16'sd2;
  localparam logic signed [CountW-1:0] ENV_SHORT_RELOAD = 16'sd4;
  localparam logic signed [CountW-1:0] LEN_SHORT_RELOAD = 16'sd3730;

  localparam logic [PeriodW-1:0] IRQ_PERIOD_RST    = 14'd14914;
  localparam logic [PeriodW-1:0] ENV_PERIOD_RST    = 14'd3728;
  localparam logic [PeriodW-1:0] LENGTH_PERIOD_RST = 14'd7456;

  localparam logic [1:0] CHECK_WINDOW_LEN = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [OffsetW-1:0] reg_offset;
    logic [DataW-1:0]   write_data;
  } fsq_item_t;

  typedef struct packed {
    logic quarter_frame_pulse;
    logic half_frame_pulse;
    logic irq_line;
    logic read_irq_bit;
  } fsq_result_t;

  typedef struct packed {
    logic [PeriodW-1:0] irq_period;
    logic [PeriodW-1:0] envelope_period;
    logic [PeriodW-1:0] length_period;
  } fsq_periods_t;

endpackage

`default_nettype wire

// ===== src/apu_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// apu_frame_sequencer
// sound-unit frame sequencer: quarter/half-frame pulses and frame irq
// ----------------------------------------------------------------------------
// Takes requests (tick, bus write or bus read) and returns exactly one result
// per request. A request is first captured in an input register; once the
// output register is free, the sequencer state is updated in a single
// combinational pass and the result is loaded into the output register, so
// the block sustains one request per cycle while the output is being taken.
// A stalled output stalls the input register, which in turn drops in_ready_o.
// The period registers are written over the cfg port, which is always ready,
// and are only to be changed while no request is in flight.
`default_nettype none

module apu_frame_sequencer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  op_i,
  input  logic [fsq_pkg::OffsetW-1:0] reg_offset_i,
  input  logic [fsq_pkg::DataW-1:0]   write_data_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        quarter_frame_pulse_o,
  output logic                        half_frame_pulse_o,
  output logic                        irq_line_o,
  output logic                        read_irq_bit_o,
  // period register writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fsq_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [fsq_pkg::PeriodW-1:0] cfg_data_i
);
  import fsq_pkg::*;

  fsq_item_t    in_item, cur_item;
  logic         cur_valid;
  logic         advance;
  fsq_periods_t periods_q;
  fsq_result_t  result, result_q;
  logic         out_valid_q;

  assign in_item = '{op: op_i, reg_offset: reg_offset_i, write_data: write_data_i};

  // request moves into the state update when the output register is free
  assign advance = cur_valid && (!out_valid_q || out_ready_i);

  fsq_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .valid_o    (cur_valid),
    .item_o     (cur_item),
    .take_i     (advance)
  );

  fsq_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (cur_item),
    .periods_i (periods_q),
    .result_o  (result)
  );

  // period registers, index past the list is dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periods_q.irq_period      <= IRQ_PERIOD_RST;
      periods_q.envelope_period <= ENV_PERIOD_RST;
      periods_q.length_period   <= LENGTH_PERIOD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_IRQ_PERIOD:    periods_q.irq_period      <= cfg_data_i;
        CFG_ENV_PERIOD:    periods_q.envelope_period <= cfg_data_i;
        CFG_LENGTH_PERIOD: periods_q.length_period   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign quarter_frame_pulse_o = result_q.quarter_frame_pulse;
  assign half_frame_pulse_o    = result_q.half_frame_pulse;
  assign irq_line_o            = result_q.irq_line;
  assign read_irq_bit_o        = result_q.read_irq_bit;

endmodule

`default_nettype wire

// ===== src/fsq_in_reg.sv =====
// ----------------------------------------------------------------------------
// fsq_in_reg
// input register stage holding one request
// ----------------------------------------------------------------------------
`default_nettype none

module fsq_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fsq_pkg::fsq_item_t item_i,
  output logic              valid_o,
  output fsq_pkg::fsq_item_t item_o,
  input  logic              take_i
);
  import fsq_pkg::*;

  logic      valid_q, valid_d;
  fsq_item_t item_q;
  logic      in_fire;

  assign in_ready_o = !valid_q || take_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (in_fire) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== src/fsq_core.sv =====
// ----------------------------------------------------------------------------
// fsq_core
// sequencer state and its single-pass update for one request
// ----------------------------------------------------------------------------
`default_nettype none

module fsq_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  fsq_pkg::fsq_item_t    item_i,
  input  fsq_pkg::fsq_periods_t periods_i,
  output fsq_pkg::fsq_result_t  result_o
);
  import fsq_pkg::*;

  logic                     odd_q, odd_d;
  logic signed [CountW-1:0] irq_cnt_q, irq_cnt_d;
  logic signed [CountW-1:0] env_cnt_q, env_cnt_d;
  logic signed [CountW-1:0] len_cnt_q, len_cnt_d;
  logic                     len_tog_q, len_tog_d;
  logic [1:0]               win_q, win_d;
  logic                     chk_q, chk_d;
  logic                     env_due_q, env_due_d;
  logic                     len_due_q, len_due_d;
  logic                     five_q, five_d;
  logic                     allow_q, allow_d;
  logic                     flag_q, flag_d;
  logic                     pend_q, pend_d;
  logic [OffsetW-1:0]       pend_offs_q, pend_offs_d;
  logic                     pend_wr_q, pend_wr_d;
  logic [DataW-1:0]         pend_data_q, pend_data_d;

  logic signed [CountW-1:0] irq_inc, env_inc, len_inc;
  logic signed [CountW-1:0] irq_per, env_per, len_per;
  fsq_result_t              res;

  assign irq_per = $signed({2'b00, periods_i.irq_period});
  assign env_per = $signed({2'b00, periods_i.envelope_period});
  assign len_per = $signed({2'b00, periods_i.length_period});
  assign irq_inc = irq_cnt_q + 16'sd1;
  assign env_inc = env_cnt_q + 16'sd1;
  assign len_inc = len_cnt_q + 16'sd1;

  always_comb begin
    odd_d       = odd_q;
    irq_cnt_d   = irq_cnt_q;
    env_cnt_d   = env_cnt_q;
    len_cnt_d   = len_cnt_q;
    len_tog_d   = len_tog_q;
    win_d       = win_q;
    chk_d       = chk_q;
    env_due_d   = env_due_q;
    len_due_d   = len_due_q;
    five_d      = five_q;
    allow_d     = allow_q;
    flag_d      = flag_q;
    pend_d      = pend_q;
    pend_offs_d = pend_offs_q;
    pend_wr_d   = pend_wr_q;
    pend_data_d = pend_data_q;
    res         = '0;

    case (item_i.op)
      OP_TICK: begin
        odd_d                   = !odd_q;
        res.quarter_frame_pulse = env_due_q;
        res.half_frame_pulse    = len_due_q;
        env_due_d               = 1'b0;
        len_due_d               = 1'b0;
        if (odd_d) begin
          // irq period counter opens the check window
          if (irq_inc >= irq_per) begin
            irq_cnt_d = CNT_RELOAD;
            chk_d     = 1'b1;
            win_d     = CHECK_WINDOW_LEN;
          end else begin
            irq_cnt_d = irq_inc;
          end
          if (env_inc >= env_per) begin
            if (chk_d && five_q) begin
              env_cnt_d = ENV_SHORT_RELOAD;
            end else begin
              env_cnt_d = CNT_RELOAD;
              env_due_d = 1'b1;
            end
          end else begin
            env_cnt_d = env_inc;
          end
          if (len_inc >= len_per) begin
            if (chk_d && five_q) begin
              len_cnt_d = LEN_SHORT_RELOAD;
              len_tog_d = 1'b1;
            end else begin
              len_tog_d = !len_tog_q;
              len_cnt_d = len_tog_d ? CNT_RELOAD_LONG : CNT_RELOAD;
              len_due_d = 1'b1;
            end
          end else begin
            len_cnt_d = len_inc;
          end
          // latched bus access lands here
          if (pend_q) begin
            pend_d = 1'b0;
            if (pend_offs_q == OFFS_FRAME && pend_wr_q) begin
              five_d    = pend_data_q[MODE_BIT];
              allow_d   = !pend_data_q[INHIBIT_BIT];
              env_cnt_d = CNT_RELOAD;
              len_cnt_d = CNT_RELOAD;
              irq_cnt_d = CNT_RELOAD;
              len_tog_d = 1'b0;
              len_due_d = five_d;
              env_due_d = five_d;
              chk_d     = 1'b0;
              if (!allow_d) begin
                flag_d = 1'b0;
              end
            end else if (pend_offs_q == OFFS_STATUS && !pend_wr_q) begin
              flag_d = 1'b0;
            end
          end
        end
        if (chk_d) begin
          if (!five_d && allow_d) begin
            flag_d = 1'b1;
          end
          win_d = win_d - 2'd1;
          if (win_d == 2'd0) begin
            chk_d = 1'b0;
          end
        end
      end
      OP_WRITE: begin
        pend_offs_d = item_i.reg_offset;
        pend_data_d = item_i.write_data;
        pend_wr_d   = 1'b1;
        pend_d      = 1'b1;
      end
      OP_READ: begin
        pend_offs_d = item_i.reg_offset;
        pend_wr_d   = 1'b0;
        pend_d      = 1'b1;
        if (item_i.reg_offset == OFFS_STATUS) begin
          res.read_irq_bit = flag_q;
        end
      end
      default: begin
      end
    endcase

    res.irq_line = flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odd_q       <= 1'b1;
      irq_cnt_q   <= CNT_RESET;
      env_cnt_q   <= CNT_RESET;
      len_cnt_q   <= CNT_RESET;
      len_tog_q   <= 1'b0;
      win_q       <= 2'd0;
      chk_q       <= 1'b0;
      env_due_q   <= 1'b0;
      len_due_q   <= 1'b0;
      five_q      <= 1'b0;
      allow_q     <= 1'b1;
      flag_q      <= 1'b0;
      pend_q      <= 1'b0;
      pend_offs_q <= '0;
      pend_wr_q   <= 1'b0;
      pend_data_q <= '0;
    end else if (advance_i) begin
      odd_q       <= odd_d;
      irq_cnt_q   <= irq_cnt_d;
      env_cnt_q   <= env_cnt_d;
      len_cnt_q   <= len_cnt_d;
      len_tog_q   <= len_tog_d;
      win_q       <= win_d;
      chk_q       <= chk_d;
      env_due_q   <= env_due_d;
      len_due_q   <= len_due_d;
      five_q      <= five_d;
      allow_q     <= allow_d;
      flag_q      <= flag_d;
      pend_q      <= pend_d;
      pend_offs_q <= pend_offs_d;
      pend_wr_q   <= pend_wr_d;
      pend_data_q <= pend_data_d;
    end
  end

  assign result_o = res;

endmodule

`default_nettype wire

// ===== src/fsq_checker.sv =====
// ----------------------------------------------------------------------------
// fsq_checker
// port-level checks of the frame sequencer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "apu_frame_sequencer_defines.svh"

module fsq_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_o,
  input  logic       out_valid_o,
  input  logic       out_ready_i,
  input  logic       quarter_frame_pulse_o,
  input  logic       half_frame_pulse_o,
  input  logic       irq_line_o,
  input  logic       read_irq_bit_o
);

  logic [3:0] out_bits;
  logic       in_fire;
  assign out_bits = {quarter_frame_pulse_o, half_frame_pulse_o, irq_line_o, read_irq_bit_o};
  assign in_fire  = in_valid_i && in_ready_o;

  // stalled result stays put
  `FSQ_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `FSQ_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_bits))
  // status read reports the flag, and a read leaves the flag set
  `FSQ_ASSERT_IMPL(a_read_bit_flag, out_valid_o && read_irq_bit_o, irq_line_o)
  // a request accepted with no result waiting shows up after the input and output registers
  `FSQ_ASSERT_NEXT(a_latency, in_fire && !out_valid_o && in_ready_o, ##1 out_valid_o)

endmodule

bind apu_frame_sequencer fsq_checker u_fsq_checker (.*);

`default_nettype wire

// ===== tb/sv/apu_frame_sequencer_checker.sv =====
// ----------------------------------------------------------------------------
// apu_frame_sequencer_checker
// watches the request, result and period write channels, keeps its own copy
// of the sequencer state and compares every result with its prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apu_frame_sequencer_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [1:0]                  op_i,
  input  logic [fsq_pkg::OffsetW-1:0] reg_offset_i,
  input  logic [fsq_pkg::DataW-1:0]   write_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic                        quarter_frame_pulse_i,
  input  logic                        half_frame_pulse_i,
  input  logic                        irq_line_i,
  input  logic                        read_irq_bit_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [fsq_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [fsq_pkg::PeriodW-1:0] cfg_data_i,
  output int                          fail_count_o,
  output int                          outstanding_o,
  output int                          checked_o,
  output int                          quarter_seen_o,
  output int                          half_seen_o,
  output int                          irq_seen_o,
  output int                          status_hits_o
);

  import fsq_pkg::*;

  localparam int PrintCap = 100;

  // period registers
  logic [PeriodW-1:0] irq_per, env_per, len_per;

  // sequencer state, counters kept wide so compares stay signed
  logic               odd_cycle;
  int                 irq_cnt, env_cnt, len_cnt;
  logic               len_flip;
  logic [1:0]         chk_window;
  logic               chk_open, env_due, len_due;
  logic               five_step, irq_enabled, irq_flag;
  logic               latch_valid, latch_write;
  logic [OffsetW-1:0] latch_offset;
  logic [DataW-1:0]   latch_data;

  fsq_result_t expected_frames[$];

  int fails, checked, quarters, halves, irqs, status_hits;

  task automatic report_mismatch(input string what, input logic got, input logic want);
    if (fails < PrintCap)
      $display("%0t ns: mismatch on result %0d, %s: got %b, want %b",
               $time, checked, what, got, want);
    fails++;
  endtask

  task automatic predict_frame_step(input logic [1:0] op_sel, input logic [OffsetW-1:0] off,
                                    input logic [DataW-1:0] byte_val,
                                    output fsq_result_t res);
    res = '0;
    case (op_sel)
      OP_TICK: begin
        odd_cycle = !odd_cycle;
        res.quarter_frame_pulse = env_due;
        res.half_frame_pulse = len_due;
        env_due = 1'b0;
        len_due = 1'b0;
        if (odd_cycle) begin
          irq_cnt++;
          if (irq_cnt >= int'(irq_per)) begin
            irq_cnt = int'(CNT_RELOAD);
            chk_open = 1'b1;
            chk_window = CHECK_WINDOW_LEN;
          end
          env_cnt++;
          if (env_cnt >= int'(env_per)) begin
            if (chk_open && five_step) begin
              env_cnt = int'(ENV_SHORT_RELOAD);
            end else begin
              env_cnt = int'(CNT_RELOAD);
              env_due = 1'b1;
            end
          end
          len_cnt++;
          if (len_cnt >= int'(len_per)) begin
            if (chk_open && five_step) begin
              len_cnt = int'(LEN_SHORT_RELOAD);
              len_flip = 1'b1;
            end else begin
              len_flip = !len_flip;
              len_cnt = int'(len_flip ? CNT_RELOAD_LONG : CNT_RELOAD);
              len_due = 1'b1;
            end
          end
          // latched bus access lands on the odd cycle
          if (latch_valid) begin
            latch_valid = 1'b0;
            if (latch_offset == OFFS_FRAME && latch_write) begin
              five_step = latch_data[MODE_BIT];
              irq_enabled = !latch_data[INHIBIT_BIT];
              irq_cnt = int'(CNT_RELOAD);
              env_cnt = int'(CNT_RELOAD);
              len_cnt = int'(CNT_RELOAD);
              len_flip = 1'b0;
              env_due = five_step;
              len_due = five_step;
              chk_open = 1'b0;
              if (!irq_enabled) irq_flag = 1'b0;
            end else if (latch_offset == OFFS_STATUS && !latch_write) begin
              irq_flag = 1'b0;
            end
          end
        end
        if (chk_open) begin
          if (!five_step && irq_enabled) irq_flag = 1'b1;
          chk_window = chk_window - 2'd1;
          if (chk_window == '0) chk_open = 1'b0;
        end
      end
      OP_WRITE: begin
        latch_offset = off;
        latch_data = byte_val;
        latch_write = 1'b1;
        latch_valid = 1'b1;
      end
      OP_READ: begin
        latch_offset = off;
        latch_write = 1'b0;
        latch_valid = 1'b1;
        if (off == OFFS_STATUS) res.read_irq_bit = irq_flag;
      end
      default: begin
      end
    endcase
    res.irq_line = irq_flag;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fsq_result_t res;
    if (!rst_ni) begin
      irq_per = IRQ_PERIOD_RST;
      env_per = ENV_PERIOD_RST;
      len_per = LENGTH_PERIOD_RST;
      odd_cycle = 1'b1;
      irq_cnt = int'(CNT_RESET);
      env_cnt = int'(CNT_RESET);
      len_cnt = int'(CNT_RESET);
      len_flip = 1'b0;
      chk_window = '0;
      chk_open = 1'b0;
      env_due = 1'b0;
      len_due = 1'b0;
      five_step = 1'b0;
      irq_enabled = 1'b1;
      irq_flag = 1'b0;
      latch_valid = 1'b0;
      latch_write = 1'b0;
      latch_offset = '0;
      latch_data = '0;
      expected_frames.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_IRQ_PERIOD:    irq_per = cfg_data_i;
          CFG_ENV_PERIOD:    env_per = cfg_data_i;
          CFG_LENGTH_PERIOD: len_per = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_frame_step(op_i, reg_offset_i, write_data_i, res);
        expected_frames.push_back(res);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("result with no request outstanding", 1'b1, 1'b0);
        end else begin
          res = expected_frames.pop_front();
          if (quarter_frame_pulse_i !== res.quarter_frame_pulse)
            report_mismatch("quarter_frame_pulse", quarter_frame_pulse_i,
                            res.quarter_frame_pulse);
          if (half_frame_pulse_i !== res.half_frame_pulse)
            report_mismatch("half_frame_pulse", half_frame_pulse_i, res.half_frame_pulse);
          if (irq_line_i !== res.irq_line)
            report_mismatch("irq_line", irq_line_i, res.irq_line);
          if (read_irq_bit_i !== res.read_irq_bit)
            report_mismatch("read_irq_bit", read_irq_bit_i, res.read_irq_bit);
        end
        checked++;
        if (quarter_frame_pulse_i === 1'b1) quarters++;
        if (half_frame_pulse_i === 1'b1) halves++;
        if (irq_line_i === 1'b1) irqs++;
        if (read_irq_bit_i === 1'b1) status_hits++;
      end
      outstanding_o <= expected_frames.size();
    end
    fail_count_o <= fails;
    checked_o <= checked;
    quarter_seen_o <= quarters;
    half_seen_o <= halves;
    irq_seen_o <= irqs;
    status_hits_o <= status_hits;
  end

endmodule

// ===== tb/sv/apu_frame_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// apu_frame_sequencer_tb
// drives ticks and latched bus accesses into the frame sequencer over a run of
// period settings and leaves prediction and comparison to the checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apu_frame_sequencer_tb;

  import fsq_pkg::*;

  // op code with no meaning for the block, must be ignored
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // no idling once this many requests went in (sender) or results came out
  localparam int CalmAfter = 780;
  // receiver holds off for a long stretch once at each of these result counts
  localparam int FirstHoldAt = 340;
  localparam int SecondHoldAt = 580;
  localparam int LongHold = 64;
  // slack at the end for results still passing the input and output registers
  localparam int DrainSlack = 8;
  // cycles with no handshake on any channel before the run is abandoned
  localparam int QuietLimit = 2000;
  localparam int RandomPhases = 8;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          op;
  logic [OffsetW-1:0]  reg_offset;
  logic [DataW-1:0]    write_data;
  logic                out_valid;
  logic                out_ready;
  logic                quarter_frame_pulse;
  logic                half_frame_pulse;
  logic                irq_line;
  logic                read_irq_bit;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [PeriodW-1:0]  cfg_data;

  int fail_count, outstanding, checked, quarter_seen, half_seen, irq_seen, status_hits;
  int items_sent = 0;
  int period_writes = 0;
  int phases_run = 0;

  always #2 clk = ~clk;

  apu_frame_sequencer dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .op_i                  (op),
    .reg_offset_i          (reg_offset),
    .write_data_i          (write_data),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_ready),
    .quarter_frame_pulse_o (quarter_frame_pulse),
    .half_frame_pulse_o    (half_frame_pulse),
    .irq_line_o            (irq_line),
    .read_irq_bit_o        (read_irq_bit),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data)
  );

  // prediction and comparison live here, the top only reports the counts
  apu_frame_sequencer_checker frame_check (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_ready_i            (in_ready),
    .op_i                  (op),
    .reg_offset_i          (reg_offset),
    .write_data_i          (write_data),
    .out_valid_i           (out_valid),
    .out_ready_i           (out_ready),
    .quarter_frame_pulse_i (quarter_frame_pulse),
    .half_frame_pulse_i    (half_frame_pulse),
    .irq_line_i            (irq_line),
    .read_irq_bit_i        (read_irq_bit),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_i           (cfg_ready),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data),
    .fail_count_o          (fail_count),
    .outstanding_o         (outstanding),
    .checked_o             (checked),
    .quarter_seen_o        (quarter_seen),
    .half_seen_o           (half_seen),
    .irq_seen_o            (irq_seen),
    .status_hits_o         (status_hits)
  );

  // result side: random stall bursts, two long hold-offs so the block fills
  // up and pushes back on the request side, then a calm tail
  initial begin
    int taken;
    int hold_left;
    bit first_hold_done;
    bit second_hold_done;
    taken = 0;
    hold_left = 0;
    first_hold_done = 1'b0;
    second_hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (hold_left == 0) begin
        if (taken >= FirstHoldAt && !first_hold_done) begin
          first_hold_done = 1'b1;
          hold_left = LongHold;
        end else if (taken >= SecondHoldAt && !second_hold_done) begin
          second_hold_done = 1'b1;
          hold_left = LongHold;
        end else if (taken < CalmAfter && $urandom_range(0, 7) == 0) begin
          hold_left = $urandom_range(1, 17);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: gives up when no channel has moved for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results still due",
             QuietLimit, outstanding);
    $display("FAILURE");
    $finish;
  end

  // one request; sometimes preceded by an idle burst with valid low
  task automatic send_item(input logic [1:0] op_sel, input logic [OffsetW-1:0] off,
                           input logic [DataW-1:0] byte_val);
    if (items_sent < CalmAfter && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= op_sel;
    reg_offset <= off;
    write_data <= byte_val;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // stop offering and wait until every result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // new period settings, only written while nothing is in flight
  task automatic set_periods(input logic [PeriodW-1:0] irq_p, input logic [PeriodW-1:0] env_p,
                             input logic [PeriodW-1:0] len_p);
    logic [PeriodW-1:0] vals [3];
    cfg_idx_e regs [3];
    vals = '{irq_p, env_p, len_p};
    regs = '{CFG_IRQ_PERIOD, CFG_ENV_PERIOD, CFG_LENGTH_PERIOD};
    wait_drained();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      period_writes++;
    end
    cfg_valid <= 1'b0;
    phases_run++;
  endtask

  // mostly ticks, with frame control writes and status reads mixed in;
  // some accesses go to other offsets and a few use the unused op code
  task automatic random_items(input int count);
    logic [1:0]         op_sel;
    logic [OffsetW-1:0] off;
    logic [DataW-1:0]   byte_val;
    int                 roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      off = OffsetW'($urandom_range(0, 31));
      byte_val = DataW'($urandom_range(0, 255));
      if (roll < 75) begin
        op_sel = OP_TICK;
      end else if (roll < 83) begin
        op_sel = OP_WRITE;
        if ($urandom_range(0, 9) < 7) off = OFFS_FRAME;
      end else if (roll < 97) begin
        op_sel = OP_READ;
        if ($urandom_range(0, 3) != 0) off = OFFS_STATUS;
      end else begin
        op_sel = OP_UNUSED;
      end
      send_item(op_sel, off, byte_val);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    op <= OP_TICK;
    reg_offset <= '0;
    write_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_IRQ_PERIOD;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // a few requests with the periods straight out of reset
    send_item(OP_READ, OFFS_STATUS, 8'h00);
    send_item(OP_UNUSED, 5'h1F, 8'hFF);
    send_item(OP_TICK, 5'h00, 8'h00);

    // directed part with short periods so the irq window opens quickly
    set_periods(14'd4, 14'd2, 14'd3);
    repeat (5) send_item(OP_TICK, 5'h00, 8'h00);
    send_item(OP_READ, OFFS_STATUS, 8'hFF);       // status read while the flag is up
    send_item(OP_TICK, 5'h1F, 8'hFF);             // tick ignores offset and data
    send_item(OP_TICK, 5'h00, 8'h00);
    send_item(OP_WRITE, OFFS_FRAME, 8'h80);       // five-step mode
    repeat (3) send_item(OP_TICK, 5'h00, 8'h00);
    send_item(OP_WRITE, OFFS_FRAME, 8'h40);       // irq inhibit ...
    send_item(OP_WRITE, OFFS_STATUS, 8'hFF);      // ... replaced before it lands
    repeat (2) send_item(OP_TICK, 5'h00, 8'h00);
    send_item(OP_READ, OFFS_FRAME, 8'h00);        // read of frame control does nothing
    send_item(OP_WRITE, 5'h00, 8'h00);            // write to some other offset
    send_item(OP_WRITE, OFFS_FRAME, 8'hC0);       // five-step and inhibit together
    repeat (2) send_item(OP_TICK, 5'h00, 8'h00);

    // period extremes: shortest, zero, longest
    set_periods(14'd1, 14'd1, 14'd1);
    random_items(80);
    set_periods(14'd0, 14'd0, 14'd0);
    random_items(60);
    set_periods(14'h3FFF, 14'h3FFF, 14'h3FFF);
    random_items(60);

    // short random periods keep the pulses and irq windows coming
    repeat (RandomPhases) begin
      set_periods(14'($urandom_range(2, 16)), 14'($urandom_range(1, 6)),
                  14'($urandom_range(1, 12)));
      random_items(80);
    end

    wait_drained();
    repeat (DrainSlack) @(posedge clk);

    $display("run: %0d requests over %0d period settings (%0d register writes), %0d results",
             items_sent, phases_run, period_writes, checked);
    $display("seen: %0d quarter-frame and %0d half-frame pulses, irq high on %0d results, %0d %s",
             quarter_seen, half_seen, irq_seen, status_hits, "status reads returned it");
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results never came", fail_count, outstanding);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
